// File: src/sbcr_pkg.sv
// ----------------------------------------------------------------------------
// sbcr_pkg: shared types and constants for the swept box collision resolver
// Widths of the fixed point formats, heading codes and register indexes.
// ----------------------------------------------------------------------------
package sbcr_pkg;

   // Coordinate, extent and contact time formats.
   localparam int COORD_BITS = 24;
   localparam int FRAC_BITS  = 8;
   localparam int EXT_BITS   = 16;
   localparam int TIME_FRAC  = 16;

   // Widths of intermediate values.
   localparam int WIDE_BITS  = COORD_BITS + 3;         // gaps and spans
   localparam int FT_BITS    = EXT_BITS + TIME_FRAC - FRAC_BITS + 1;
   localparam int NUM_BITS   = WIDE_BITS + TIME_FRAC;  // scaled gap
   localparam int PROD_BITS  = FT_BITS + COORD_BITS;
   localparam int SMALL_BITS = COORD_BITS + 7;

   // Magnitude bound of a small contact time, in units of 2^-16.
   localparam logic [6:0] SMALL_TIME = 7'd66;

   // Heading codes.
   localparam logic [1:0] HEAD_POS = 2'd1;
   localparam logic [1:0] HEAD_NEG = 2'd2;

   // Register indexes.
   localparam logic [2:0] REG_TILE_LEFT  = 3'd0;
   localparam logic [2:0] REG_TILE_TOP   = 3'd1;
   localparam logic [2:0] REG_TILE_EXT_X = 3'd2;
   localparam logic [2:0] REG_TILE_EXT_Y = 3'd3;
   localparam logic [2:0] REG_MOVE_EXT_X = 3'd4;
   localparam logic [2:0] REG_MOVE_EXT_Y = 3'd5;

   // Static geometry of one axis.
   typedef struct packed {
      logic signed [COORD_BITS-1:0] lo;
      logic [EXT_BITS-1:0]          tile_ext;
      logic [EXT_BITS-1:0]          move_ext;
   } axis_cfg_type;

endpackage

// File: src/sbcr_axis.sv
// ----------------------------------------------------------------------------
// sbcr_axis: one axis of the collision resolver
// Three register stages: input capture, gap and clamp setup, products. The
// contact time test is done by cross multiplication instead of division.
// ----------------------------------------------------------------------------
module sbcr_axis import sbcr_pkg::*; (
   input  logic                         clock,
   input  logic signed [COORD_BITS-1:0] newp,
   input  logic signed [COORD_BITS-1:0] step,
   input  logic [1:0]                   head,
   input  logic                         span_ok,
   input  logic [EXT_BITS-1:0]          frame_time,
   input  axis_cfg_type                 cfg,
   output logic signed [COORD_BITS-1:0] fixed,
   output logic                         hit
);

   // Stage 1 registers.
   logic signed [COORD_BITS-1:0] newp1_ff, step1_ff;
   logic [1:0]                   head1_ff;
   logic                         span1_ff;
   logic [EXT_BITS-1:0]          ft1_ff;

   always_ff @(posedge clock) begin
      newp1_ff <= newp;
      step1_ff <= step;
      head1_ff <= head;
      span1_ff <= span_ok;
      ft1_ff   <= frame_time;
   end

   // Stage 2 setup: gap, divisor magnitude, sign and clamp target.
   logic signed [WIDE_BITS-1:0]  old_w, lo_w, et_w, em_w, newp_w, num_pos, num_neg, num;
   logic signed [WIDE_BITS-1:0]  reach_lo, reach_hi, clamp_w;
   logic [WIDE_BITS-1:0]         a_in;
   logic [COORD_BITS-1:0]        b_in;
   logic                         pos_in, act_in, is_pos, is_neg;
   logic signed [COORD_BITS-1:0] clamp_in;
   logic [FT_BITS-1:0]           ftp_in;

   always_comb begin
      newp_w   = WIDE_BITS'(newp1_ff);
      old_w    = newp_w - WIDE_BITS'(step1_ff);
      lo_w     = WIDE_BITS'(cfg.lo);
      et_w     = $signed(WIDE_BITS'(cfg.tile_ext));
      em_w     = $signed(WIDE_BITS'(cfg.move_ext));
      is_pos   = (head1_ff == HEAD_POS);
      is_neg   = (head1_ff == HEAD_NEG);
      num_pos  = lo_w - (old_w + em_w);
      num_neg  = old_w - (lo_w + et_w);
      num      = is_pos ? num_pos : num_neg;
      a_in     = num[WIDE_BITS-1] ? WIDE_BITS'(-num) : WIDE_BITS'(num);
      b_in     = step1_ff[COORD_BITS-1] ? COORD_BITS'(-step1_ff) : COORD_BITS'(step1_ff);
      // A negative heading divides by the magnitude, so only the gap sign counts.
      pos_in   = is_pos ? !(num[WIDE_BITS-1] ^ step1_ff[COORD_BITS-1])
                        : !num[WIDE_BITS-1];
      reach_lo = lo_w - em_w;
      reach_hi = lo_w + et_w;
      act_in   = span1_ff && (step1_ff != '0) &&
                 ((is_pos && (newp_w + em_w > lo_w)) || (is_neg && (newp_w < reach_hi)));
      clamp_w  = is_pos ? reach_lo : reach_hi;
      // Saturate the clamp target to the coordinate range.
      if (clamp_w > $signed(WIDE_BITS'({1'b0, {(COORD_BITS-1){1'b1}}})))
         clamp_in = {1'b0, {(COORD_BITS-1){1'b1}}};
      else if (clamp_w < WIDE_BITS'($signed({1'b1, {(COORD_BITS-1){1'b0}}})))
         clamp_in = {1'b1, {(COORD_BITS-1){1'b0}}};
      else
         clamp_in = COORD_BITS'(clamp_w);
      ftp_in   = FT_BITS'({ft1_ff, {(TIME_FRAC-FRAC_BITS){1'b0}}}) + FT_BITS'(1);
   end

   // Stage 2 registers.
   logic [WIDE_BITS-1:0]         a2_ff;
   logic [COORD_BITS-1:0]        b2_ff;
   logic                         pos2_ff, act2_ff;
   logic signed [COORD_BITS-1:0] clamp2_ff, newp2_ff;
   logic [FT_BITS-1:0]           ftp2_ff;

   always_ff @(posedge clock) begin
      a2_ff     <= a_in;
      b2_ff     <= b_in;
      pos2_ff   <= pos_in;
      act2_ff   <= act_in;
      clamp2_ff <= clamp_in;
      newp2_ff  <= newp1_ff;
      ftp2_ff   <= ftp_in;
   end

   // Stage 3: bound products of the divisor, registered.
   logic [PROD_BITS-1:0]         prod3_ff;
   logic [SMALL_BITS-1:0]        small3_ff;
   logic [NUM_BITS-1:0]          an3_ff;
   logic                         pos3_ff, act3_ff;
   logic signed [COORD_BITS-1:0] clamp3_ff, newp3_ff;

   always_ff @(posedge clock) begin
      prod3_ff  <= PROD_BITS'(ftp2_ff) * PROD_BITS'(b2_ff);
      small3_ff <= SMALL_BITS'(b2_ff) * SMALL_BITS'(SMALL_TIME);
      an3_ff    <= {a2_ff, {TIME_FRAC{1'b0}}};
      pos3_ff   <= pos2_ff;
      act3_ff   <= act2_ff;
      clamp3_ff <= clamp2_ff;
      newp3_ff  <= newp2_ff;
   end

   // Contact time test: t in [0, frame time] or |t| under the small bound.
   logic time_ok;

   always_comb begin
      time_ok = (an3_ff < NUM_BITS'(small3_ff)) ||
                (pos3_ff && (PROD_BITS'(an3_ff) < prod3_ff));
      hit     = act3_ff && time_ok;
      fixed   = hit ? clamp3_ff : newp3_ff;
   end

endmodule

// File: src/swept_box_collision_resolve.sv
// ----------------------------------------------------------------------------
// swept_box_collision_resolve: clamps a moving box against one static tile
// Top level with the register file, span tests and result register.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge with start high and busy low. busy is
//   always low, so one item can be taken in every cycle.
//   Each item gives one result on the rsp_ ports, marked by rsp_valid for
//   exactly one cycle. Results come in the order of the items.
//   The pipeline stages are a capture stage, a setup stage for the gaps,
//   a stage for the divisor products and the result register, in that
//   order. The contact time is tested by multiplying the divisor with the
//   time bounds, so the pipeline carries one item per cycle.
//   The tile and box geometry sit in six registers written over the csr_
//   channel, which is always ready. Write them only while no item is in
//   flight.
//   Reset clears the pipeline valid bits and restores the default geometry.
//   The receiver cannot stall; results must be taken as they appear.
// ----------------------------------------------------------------------------
module swept_box_collision_resolve import sbcr_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_step_x,
   input  logic signed [COORD_BITS-1:0] req_step_y,
   input  logic [1:0]                   req_heading_x,
   input  logic [1:0]                   req_heading_y,
   input  logic [EXT_BITS-1:0]          req_frame_time,
   output logic                         rsp_valid,
   output logic signed [COORD_BITS-1:0] rsp_fixed_x,
   output logic signed [COORD_BITS-1:0] rsp_fixed_y,
   output logic                         rsp_hit_on_x,
   output logic                         rsp_hit_on_y,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [2:0]                   csr_index,
   input  logic [COORD_BITS-1:0]        csr_data
);

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Configuration registers.
   logic signed [COORD_BITS-1:0] tile_left_ff, tile_top_ff;
   logic [EXT_BITS-1:0]          tile_ext_x_ff, tile_ext_y_ff, move_ext_x_ff, move_ext_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_left_ff  <= '0;
         tile_top_ff   <= '0;
         tile_ext_x_ff <= 16'd25600;
         tile_ext_y_ff <= 16'd25600;
         move_ext_x_ff <= 16'd10240;
         move_ext_y_ff <= 16'd10240;
      end else if (csr_valid) begin
         case (csr_index)
            REG_TILE_LEFT:  tile_left_ff  <= csr_data;
            REG_TILE_TOP:   tile_top_ff   <= csr_data;
            REG_TILE_EXT_X: tile_ext_x_ff <= EXT_BITS'(csr_data);
            REG_TILE_EXT_Y: tile_ext_y_ff <= EXT_BITS'(csr_data);
            REG_MOVE_EXT_X: move_ext_x_ff <= EXT_BITS'(csr_data);
            REG_MOVE_EXT_Y: move_ext_y_ff <= EXT_BITS'(csr_data);
            default: ;
         endcase
      end
   end

   axis_cfg_type cfg_x, cfg_y;
   assign cfg_x = '{lo: tile_left_ff, tile_ext: tile_ext_x_ff, move_ext: move_ext_x_ff};
   assign cfg_y = '{lo: tile_top_ff,  tile_ext: tile_ext_y_ff, move_ext: move_ext_y_ff};

   // Old span tests: an axis is resolved only if the other axis overlaps.
   logic signed [WIDE_BITS-1:0] old_x, old_y, far_x, far_y, end_x, end_y;
   logic signed [WIDE_BITS-1:0] lo_x, lo_y;
   logic                        span_x, span_y;

   always_comb begin
      old_x  = WIDE_BITS'(req_pos_x) - WIDE_BITS'(req_step_x);
      old_y  = WIDE_BITS'(req_pos_y) - WIDE_BITS'(req_step_y);
      far_x  = old_x + $signed(WIDE_BITS'(move_ext_x_ff));
      far_y  = old_y + $signed(WIDE_BITS'(move_ext_y_ff));
      lo_x   = WIDE_BITS'(tile_left_ff);
      lo_y   = WIDE_BITS'(tile_top_ff);
      end_x  = lo_x + $signed(WIDE_BITS'(tile_ext_x_ff));
      end_y  = lo_y + $signed(WIDE_BITS'(tile_ext_y_ff));
      span_y = (old_x > lo_x && old_x < end_x) || (far_x > lo_x && far_x < end_x);
      span_x = (old_y > lo_y && old_y < end_y) || (far_y > lo_y && far_y < end_y);
   end

   // Axis pipelines.
   logic signed [COORD_BITS-1:0] fix_x, fix_y;
   logic                         hit_x, hit_y;

   sbcr_axis u_axis_x (
      .clock      (clock),
      .newp       (req_pos_x),
      .step       (req_step_x),
      .head       (req_heading_x),
      .span_ok    (span_x),
      .frame_time (req_frame_time),
      .cfg        (cfg_x),
      .fixed      (fix_x),
      .hit        (hit_x)
   );

   sbcr_axis u_axis_y (
      .clock      (clock),
      .newp       (req_pos_y),
      .step       (req_step_y),
      .head       (req_heading_y),
      .span_ok    (span_y),
      .frame_time (req_frame_time),
      .cfg        (cfg_y),
      .fixed      (fix_y),
      .hit        (hit_y)
   );

   // Valid bits travel beside the axis stages.
   logic [2:0] vld_ff, vld_in;
   logic       out_vld_ff;

   assign vld_in = {vld_ff[1:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= vld_in;
         out_vld_ff <= vld_ff[2];
      end
   end

   // Result register.
   logic signed [COORD_BITS-1:0] fix_x_ff, fix_y_ff;
   logic                         hit_x_ff, hit_y_ff;

   always_ff @(posedge clock) begin
      fix_x_ff <= fix_x;
      fix_y_ff <= fix_y;
      hit_x_ff <= hit_x;
      hit_y_ff <= hit_y;
   end

   assign rsp_valid    = out_vld_ff;
   assign rsp_fixed_x  = fix_x_ff;
   assign rsp_fixed_y  = fix_y_ff;
   assign rsp_hit_on_x = hit_x_ff;
   assign rsp_hit_on_y = hit_y_ff;

   // Every accepted item yields a result.
   a_item_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("item without result");

   // No result appears without a matching earlier item.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(reset, 4) && !$past(reset, 3) && !$past(reset, 2)
       && !$past(reset, 1)) |-> $past(start, 4))
      else $error("result without item");

   // The pipeline is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result after reset");

endmodule
